// ===== hdl/sdpg_pkg.sv =====
// Shared constants, request/result types and register indexes for the step/dir generator.
package sdpg_pkg;

    // Timing constants in microsecond ticks, and field widths
    localparam int unsigned MIN_PULSE_US = 5;
    localparam int unsigned GUARD_US     = 0;
    localparam int unsigned PH_W         = 26;
    localparam int unsigned STEPS_W      = 31;
    localparam int unsigned POS_W        = 32;
    localparam int unsigned REG_W        = 16;

    localparam logic [PH_W-1:0] HIGH_TICKS =
        PH_W'((MIN_PULSE_US < 1) ? 1 : MIN_PULSE_US);
    localparam logic [PH_W-1:0] LOW_SUB = PH_W'(MIN_PULSE_US + GUARD_US);

    // Serial divider width and microseconds in one minute
    localparam int unsigned DIV_W = 32;
    localparam int unsigned CNT_W = $clog2(DIV_W + 1);
    localparam logic [DIV_W-1:0] US_PER_MINUTE = DIV_W'(60000000);

    // Request kinds
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_MOVE   = 2'd1;
    localparam logic [1:0] REQ_SETPOS = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [31:0] step_count;
        logic signed [31:0] new_position;
    } t_req;

    // Result item
    typedef struct packed {
        logic               step_pin;
        logic               dir_pin;
        logic               enable_pin;
        logic               busy_res;
        logic               cmd_rejected;
        logic signed [31:0] position;
        logic [15:0]        step_in_rev;
    } t_res;

endpackage

// ===== hdl/sdpg_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module sdpg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sdpg_pkg::DIV_W-1:0]    i_dividend,
    input  logic [sdpg_pkg::DIV_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [sdpg_pkg::DIV_W-1:0]    o_quo,
    output logic [sdpg_pkg::DIV_W-1:0]    o_rem
);

    logic [sdpg_pkg::CNT_W-1:0] r_cnt;
    logic                       r_done;
    logic [sdpg_pkg::DIV_W-1:0] r_rem;
    logic [sdpg_pkg::DIV_W-1:0] r_quo;
    logic [sdpg_pkg::DIV_W-1:0] r_dvs;

    logic [sdpg_pkg::DIV_W:0]   trial;
    logic [sdpg_pkg::DIV_W:0]   diff;
    logic                       fits;

    // One shift-subtract step
    always_comb begin
        trial = {r_rem, r_quo[sdpg_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
    end

    // Control: bit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == sdpg_pkg::CNT_W'(1));
            if (i_start) begin
                r_cnt <= sdpg_pkg::CNT_W'(sdpg_pkg::DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - sdpg_pkg::CNT_W'(1);
            end
        end
    end

    // Datapath: remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? diff[sdpg_pkg::DIV_W-1:0] : trial[sdpg_pkg::DIV_W-1:0];
            r_quo <= {r_quo[sdpg_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== hdl/step_dir_pulse_generator.sv =====
// Top level: step/dir pulse generator with config registers, sequencer and output register.
// Sequence: a tick, set-position, refused or unused item passes S_REVS, S_REV and S_OUT;
//   an accepted move passes S_PER (period division), S_REV (step_in_rev division), S_OUT.
//   The input stalls outside S_IDLE, also while S_OUT waits on an output stall; the shared
//   32-bit serial divider (one quotient bit per cycle) does both divisions.
// Reset (i_rst_n low, synchronous): position, motion state and output valid clear;
//   speed_rpm = 60, steps_per_rev = 200, enable_level = 1.
module step_dir_pulse_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  sdpg_pkg::t_req                     i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output sdpg_pkg::t_res                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sdpg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sdpg_pkg::REG_W-1:0]         i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PER  = 5'b00010,
        S_REVS = 5'b00100,
        S_REV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [sdpg_pkg::REG_W-1:0] r_speed;
    logic [sdpg_pkg::REG_W-1:0] r_spr;
    logic                       r_en;

    // Motion state
    logic [sdpg_pkg::POS_W-1:0]   r_position, n_position;
    logic [sdpg_pkg::STEPS_W-1:0] r_steps_left, n_steps_left;
    logic [sdpg_pkg::PH_W-1:0]    r_period;
    logic [sdpg_pkg::PH_W-1:0]    r_phase, n_phase;
    logic                         r_pulse_high, n_pulse_high;
    logic                         r_dir, n_dir;
    logic                         r_rej, n_rej;
    logic [15:0]                  r_sir;

    // Output register
    logic                         r_out_valid;
    sdpg_pkg::t_res               r_out;

    logic                         in_acc;
    logic                         busy;
    logic                         out_free;
    logic [sdpg_pkg::PH_W-1:0]    ph_dec;
    logic [sdpg_pkg::PH_W-1:0]    low_ticks;
    logic [sdpg_pkg::POS_W-1:0]   cnt_neg;
    logic [sdpg_pkg::STEPS_W-1:0] mag;
    logic [31:0]                  prod;
    logic [sdpg_pkg::POS_W-1:0]   pos_mag;
    logic [15:0]                  rem16;
    logic [15:0]                  sir_calc;

    logic                         div_start;
    logic [sdpg_pkg::DIV_W-1:0]   div_dvd;
    logic [sdpg_pkg::DIV_W-1:0]   div_dvs;
    logic                         div_done;
    logic [sdpg_pkg::DIV_W-1:0]   div_quo;
    logic [sdpg_pkg::DIV_W-1:0]   div_rem;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign busy        = (r_steps_left != '0) || (r_phase != '0);

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= sdpg_pkg::REG_W'(60);
            r_spr   <= sdpg_pkg::REG_W'(200);
            r_en    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sdpg_pkg::CFG_SPEED:  r_speed <= i_cfg_data;
                sdpg_pkg::CFG_SPR:    r_spr   <= i_cfg_data;
                sdpg_pkg::CFG_ENABLE: r_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Helper values for the motion update
    always_comb begin
        ph_dec    = r_phase - sdpg_pkg::PH_W'(1);
        low_ticks = (r_period > sdpg_pkg::LOW_SUB) ? (r_period - sdpg_pkg::LOW_SUB)
                                                   : sdpg_pkg::PH_W'(1);
        cnt_neg   = 32'd0 - 32'(i_in_data.step_count);
        if (i_in_data.step_count[31]) begin
            mag = cnt_neg[31] ? {sdpg_pkg::STEPS_W{1'b1}} : cnt_neg[30:0];
        end else begin
            mag = i_in_data.step_count[30:0];
        end
        prod    = 32'(r_speed) * 32'(r_spr);
        pos_mag = r_position[31] ? (32'd0 - r_position) : r_position;
    end

    // Motion update on an input transfer
    always_comb begin
        n_position   = r_position;
        n_steps_left = r_steps_left;
        n_phase      = r_phase;
        n_pulse_high = r_pulse_high;
        n_dir        = r_dir;
        n_rej        = r_rej;
        if (in_acc) begin
            n_rej = 1'b0;
            case (i_in_data.req_type)
                sdpg_pkg::REQ_TICK: begin
                    if (r_phase != '0) begin
                        n_phase = ph_dec;
                        if (ph_dec == '0) begin
                            if (r_pulse_high) begin
                                n_pulse_high = 1'b0;
                                n_position   = r_dir ? (r_position + 32'd1)
                                                     : (r_position - 32'd1);
                                n_steps_left = r_steps_left - sdpg_pkg::STEPS_W'(1);
                                n_phase      = low_ticks;
                            end else if (r_steps_left != '0) begin
                                n_pulse_high = 1'b1;
                                n_phase      = sdpg_pkg::HIGH_TICKS;
                            end
                        end
                    end
                end
                sdpg_pkg::REQ_MOVE: begin
                    if (busy) begin
                        n_rej = 1'b1;
                    end else begin
                        n_dir        = !i_in_data.step_count[31];
                        n_steps_left = mag;
                        if (mag != '0) begin
                            n_pulse_high = 1'b1;
                            n_phase      = sdpg_pkg::HIGH_TICKS;
                        end
                    end
                end
                sdpg_pkg::REQ_SETPOS: begin
                    if (busy) begin
                        n_rej = 1'b1;
                    end else begin
                        n_position = i_in_data.new_position;
                    end
                end
                default: ;
            endcase
        end
    end

    // Divider operand selection
    always_comb begin
        div_start = 1'b0;
        div_dvd   = pos_mag;
        div_dvs   = {16'd0, r_spr};
        if (in_acc && !busy && (i_in_data.req_type == sdpg_pkg::REQ_MOVE)) begin
            div_start = 1'b1;
            div_dvd   = sdpg_pkg::US_PER_MINUTE;
            div_dvs   = (prod == 32'd0) ? 32'd1 : prod;
        end else if (((r_state == S_PER) && div_done) || (r_state == S_REVS)) begin
            div_start = 1'b1;
        end
    end

    // Position modulo steps per revolution, folded for negative positions
    always_comb begin
        rem16 = div_rem[15:0];
        if (r_spr == '0) begin
            sir_calc = '0;
        end else if (r_position[31] && (rem16 != '0)) begin
            sir_calc = r_spr - rem16;
        end else begin
            sir_calc = rem16;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = div_start ? S_PER : S_REVS;
                end
            end
            S_PER:  if (div_done) n_state = S_REV;
            S_REVS: n_state = S_REV;
            S_REV:  if (div_done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control and motion registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_position   <= '0;
            r_steps_left <= '0;
            r_period     <= '0;
            r_phase      <= '0;
            r_pulse_high <= 1'b0;
            r_dir        <= 1'b0;
            r_rej        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_position   <= n_position;
            r_steps_left <= n_steps_left;
            r_phase      <= n_phase;
            r_pulse_high <= n_pulse_high;
            r_dir        <= n_dir;
            r_rej        <= n_rej;
            if ((r_state == S_PER) && div_done) begin
                r_period <= div_quo[sdpg_pkg::PH_W-1:0];
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_REV) && div_done) begin
            r_sir <= sir_calc;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out.step_pin     <= r_pulse_high;
            r_out.dir_pin      <= r_dir;
            r_out.enable_pin   <= r_en;
            r_out.busy_res     <= busy;
            r_out.cmd_rejected <= r_rej;
            r_out.position     <= r_position;
            r_out.step_in_rev  <= r_sir;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    sdpg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // One item at a time: a transfer closes the input until the result is out
    a_acc_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> ((r_state == S_PER) || (r_state == S_REV)))
        else $error("divider done outside a divide state");

    // A high step pulse always has time left on the phase timer
    a_pulse_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse_high |-> (r_phase != '0))
        else $error("step pulse high with expired phase timer");

    // A new result appears only out of the output state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result valid raised outside the output state");

endmodule
